// ===== hw/rtl/tdc_pkg.sv =====
// tdc_pkg: shared constants for the tilt direction classifier
// direction codes, register map, reset values and field widths
// no dependencies
package tdc_pkg;

  // window depth default and configuration reset value
  localparam int unsigned WINDOW_DEPTH_DEF = 5;
  localparam logic [14:0] THRESHOLD_RESET  = 15'd5000;

  // field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned THR_W    = 15;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned CHAR_W   = 6;

  // configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic [CFG_AW-1:0] ADDR_TILT_THRESHOLD = 3'd0;

  // direction codes
  localparam logic [CODE_W-1:0] DIR_STOP     = 3'd0;
  localparam logic [CODE_W-1:0] DIR_FORWARD  = 3'd1;
  localparam logic [CODE_W-1:0] DIR_BACKWARD = 3'd2;
  localparam logic [CODE_W-1:0] DIR_LEFT     = 3'd3;
  localparam logic [CODE_W-1:0] DIR_RIGHT    = 3'd4;

  // ascii digit zero
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;

endpackage

// ===== hw/rtl/tdc_lane.sv =====
// tdc_lane: one axis lane, a shift line of the last samples and a running sum
// depends on tdc_pkg
module tdc_lane #(
  parameter int unsigned WINDOW_DEPTH = tdc_pkg::WINDOW_DEPTH_DEF,
  localparam int unsigned SUM_W = 17 + $clog2(WINDOW_DEPTH)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic signed [tdc_pkg::SAMPLE_W-1:0]  sample,
  output logic signed [SUM_W-1:0]              sum
);

  logic signed [tdc_pkg::SAMPLE_W-1:0] taps_r [WINDOW_DEPTH];
  logic signed [SUM_W-1:0]             sum_r;
  logic signed [SUM_W-1:0]             sum_nxt;

  // new sample enters, oldest leaves the window
  assign sum_nxt = sum_r + SUM_W'(sample) - SUM_W'(taps_r[WINDOW_DEPTH-1]);

  // shift line and sum, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
        taps_r[k] <= '0;
      end
      sum_r <= '0;
    end else if (load) begin
      taps_r[0] <= sample;
      for (int k = 1; k < WINDOW_DEPTH; k++) begin
        taps_r[k] <= taps_r[k-1];
      end
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

// ===== hw/rtl/tdc_merge.sv =====
// tdc_merge: compares both lane sums with the scaled threshold, picks a
// direction and registers a result item when it changes; depends on tdc_pkg
module tdc_merge #(
  parameter int unsigned WINDOW_DEPTH = tdc_pkg::WINDOW_DEPTH_DEF,
  localparam int unsigned SUM_W = 17 + $clog2(WINDOW_DEPTH)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               sum_valid,
  input  logic signed [SUM_W-1:0]            sum_x,
  input  logic signed [SUM_W-1:0]            sum_y,
  input  logic [tdc_pkg::THR_W-1:0]          threshold,
  output logic                               take,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tdc_pkg::CODE_W-1:0]         out_code,
  output logic [tdc_pkg::CHAR_W-1:0]         out_char
);

  logic                        stall;
  logic [SUM_W-1:0]            lim_u;
  logic signed [SUM_W-1:0]     lim_pos;
  logic signed [SUM_W-1:0]     lim_neg;
  logic [tdc_pkg::CODE_W-1:0]  dir;
  logic                        changed;
  logic                        load;
  logic [tdc_pkg::CODE_W-1:0]  prev_r;
  logic                        out_valid_r;
  logic [tdc_pkg::CODE_W-1:0]  out_code_r;
  logic [tdc_pkg::CHAR_W-1:0]  out_char_r;

  // trunc(sum/depth) > thr  <=>  sum >= (thr+1)*depth, mirrored for the negative side
  assign lim_u   = SUM_W'({1'b0, threshold} + 16'd1) * SUM_W'(WINDOW_DEPTH);
  assign lim_pos = signed'(lim_u);
  assign lim_neg = -lim_pos;

  // priority: forward, backward, right, left, stop
  always_comb begin
    if (sum_y <= lim_neg) begin
      dir = tdc_pkg::DIR_FORWARD;
    end else if (sum_y >= lim_pos) begin
      dir = tdc_pkg::DIR_BACKWARD;
    end else if (sum_x <= lim_neg) begin
      dir = tdc_pkg::DIR_RIGHT;
    end else if (sum_x >= lim_pos) begin
      dir = tdc_pkg::DIR_LEFT;
    end else begin
      dir = tdc_pkg::DIR_STOP;
    end
  end

  assign stall   = out_valid_r && !out_ready;
  assign take    = sum_valid && !stall;
  assign load    = take && changed;
  assign changed = (dir != prev_r);

  // previous direction and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= tdc_pkg::DIR_STOP;
      out_valid_r <= 1'b0;
    end else if (!stall) begin
      out_valid_r <= load;
      if (take) begin
        prev_r <= dir;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_code_r <= dir;
      out_char_r <= tdc_pkg::CHAR_ZERO + tdc_pkg::CHAR_W'(dir);
    end
  end

  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;
  assign out_char  = out_char_r;

  // a held result is a legal code
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_code_r <= tdc_pkg::DIR_RIGHT))
    else $error("result code out of range");

  // digit matches the code
  a_char_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r == tdc_pkg::CHAR_ZERO + tdc_pkg::CHAR_W'(out_code_r)))
    else $error("direction digit does not match code");

  // a loaded result is the new direction and differs from the old one
  a_load_change: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_valid_r && out_code_r == prev_r && prev_r != $past(prev_r)))
    else $error("result loaded without a change of direction");

endmodule

// ===== hw/rtl/tilt_direction_classifier_top.sv =====
// tilt_direction_classifier_top: apb register, input handshake, two axis
// lanes and the merging stage; depends on tdc_pkg, tdc_lane, tdc_merge
//
// Usage:
//   in_* carries one item per accepted beat: an (x, y) accelerometer sample
//   pair. Each axis keeps a window of the last WINDOW_DEPTH samples with a
//   running sum; the window average, truncated toward zero, is compared
//   against tilt_threshold (apb register at address 0, reset 5000).
//   out_* carries an item only when the chosen direction differs from the
//   previous one (0 stop, 1 forward, 2 backward, 3 left, 4 right).
//   A result passes through the lane registers and then the output register
//   before it appears on out_tvalid. Throughput: one item per cycle while the
//   output is not stalled, set by the running-sum update in each lane.
//   Reset (rst_n low, synchronous) clears both windows, the previous
//   direction (stop) and the threshold to 5000.
//   When the receiver stalls, the output register holds its item and one
//   more item can still be accepted into the lane stage; after that
//   in_tready drops until the result is taken.
module tilt_direction_classifier_top #(
  parameter int unsigned WINDOW_DEPTH = tdc_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input item
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // [15:0] sample_x, [31:16] sample_y
  // result item
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // [2:0] direction_code, [8:3] direction_char
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tdc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [tdc_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [tdc_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int unsigned SUM_W = 17 + $clog2(WINDOW_DEPTH);

  logic [tdc_pkg::THR_W-1:0]   thr_r;
  logic                        cfg_wr;
  logic                        in_acc;
  logic                        s1_valid_r;
  logic                        take;
  logic signed [SUM_W-1:0]     sum_x;
  logic signed [SUM_W-1:0]     sum_y;
  logic [tdc_pkg::CODE_W-1:0]  out_code;
  logic [tdc_pkg::CHAR_W-1:0]  out_char;

  // register write and read
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr == tdc_pkg::ADDR_TILT_THRESHOLD);
  assign cfg_prdata = (cfg_paddr == tdc_pkg::ADDR_TILT_THRESHOLD)
                      ? tdc_pkg::CFG_DW'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= tdc_pkg::THRESHOLD_RESET;
    end else if (cfg_wr) begin
      thr_r <= cfg_pwdata[tdc_pkg::THR_W-1:0];
    end
  end

  // lane stage takes an item when empty or being drained
  assign in_tready = !s1_valid_r || take;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc || take) begin
      s1_valid_r <= in_acc;
    end
  end

  // x and y lanes
  tdc_lane #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (in_acc),
    .sample (signed'(in_tdata[15:0])),
    .sum    (sum_x)
  );

  tdc_lane #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (in_acc),
    .sample (signed'(in_tdata[31:16])),
    .sum    (sum_y)
  );

  // classification and change detection
  tdc_merge #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (s1_valid_r),
    .sum_x     (sum_x),
    .sum_y     (sum_y),
    .threshold (thr_r),
    .take      (take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_code  (out_code),
    .out_char  (out_char)
  );

  assign out_tdata = {7'd0, out_char, out_code};

  // a pending lane item is never dropped while the output stalls
  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !take) |=> s1_valid_r)
    else $error("lane item lost while stalled");

  // no accept while the lane stage is full and blocked
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !take) |-> !in_acc)
    else $error("item accepted over a blocked lane stage");

  // threshold takes the written value
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (thr_r == $past(cfg_pwdata[tdc_pkg::THR_W-1:0])))
    else $error("threshold write not taken");

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for tilt_direction_classifier_top, stream item in,
// direction change items out, threshold set over the apb port
// depends on tdc_pkg and the top level rtl
module tb;

  localparam int WINDOW       = tdc_pkg::WINDOW_DEPTH_DEF;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 175;
  localparam int PHASE_COUNT  = 8;
  localparam logic [tdc_pkg::CFG_AW-1:0] ADDR_UNMAPPED = 3'd4;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic signed [tdc_pkg::SAMPLE_W-1:0] x;
    logic signed [tdc_pkg::SAMPLE_W-1:0] y;
  } sample_t;

  typedef struct {
    logic [tdc_pkg::CODE_W-1:0] code;
    logic [tdc_pkg::CHAR_W-1:0] chr;
  } direction_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_tvalid   = 1'b0;
  logic                       in_tready;
  logic [31:0]                in_tdata    = '0;   // [15:0] sample_x, [31:16] sample_y
  logic                       out_tvalid;
  logic                       out_tready  = 1'b0;
  logic [15:0]                out_tdata;          // [2:0] direction_code, [8:3] direction_char
  logic                       cfg_psel    = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite  = 1'b0;
  logic [tdc_pkg::CFG_AW-1:0] cfg_paddr   = '0;
  logic [tdc_pkg::CFG_DW-1:0] cfg_pwdata  = '0;
  logic [tdc_pkg::CFG_DW-1:0] cfg_prdata;
  logic                       cfg_pready;

  // predictor state
  logic signed [tdc_pkg::SAMPLE_W-1:0] x_ring [WINDOW];
  logic signed [tdc_pkg::SAMPLE_W-1:0] y_ring [WINDOW];
  int                                  ring_slot;
  logic [tdc_pkg::CODE_W-1:0]          held_direction;
  logic [tdc_pkg::THR_W-1:0]           tilt_thr;

  sample_t    sample_queue[$];
  direction_t direction_due[$];
  int         samples_left = 0;
  int         mismatches   = 0;
  idle_mode_t idle_mode    = IDLE_NONE;
  sample_t    offered;
  direction_t want;

  // long receiver hold-off, requested by toggling
  logic hold_req  = 1'b0;
  logic hold_ack  = 1'b0;
  int   hold_left = 0;

  tilt_direction_classifier_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // direction from the two window averages, y axis first
  function automatic logic [tdc_pkg::CODE_W-1:0] classify_tilt(input int ax, input int ay,
                                                               input int thr);
    if (ay < -thr) return tdc_pkg::DIR_FORWARD;
    if (ay > thr)  return tdc_pkg::DIR_BACKWARD;
    if (ax < -thr) return tdc_pkg::DIR_RIGHT;
    if (ax > thr)  return tdc_pkg::DIR_LEFT;
    return tdc_pkg::DIR_STOP;
  endfunction

  // store one sample pair, average both windows, queue a change of direction
  task automatic advance_windows(input sample_t s);
    int sum_x;
    int sum_y;
    logic [tdc_pkg::CODE_W-1:0] dir;
    direction_t d;
    sum_x = 0;
    sum_y = 0;
    x_ring[ring_slot] = s.x;
    y_ring[ring_slot] = s.y;
    for (int k = 0; k < WINDOW; k++) begin
      sum_x += int'(x_ring[k]);
      sum_y += int'(y_ring[k]);
    end
    ring_slot = (ring_slot + 1) % WINDOW;
    dir = classify_tilt(sum_x / WINDOW, sum_y / WINDOW, int'(tilt_thr));
    if (dir != held_direction) begin
      d.code = dir;
      d.chr  = tdc_pkg::CHAR_ZERO + tdc_pkg::CHAR_W'(dir);
      direction_due.push_back(d);
    end
    held_direction = dir;
  endtask

  function automatic bit pass_gate(input bit active);
    if (!active) return 1'b1;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) >= 10;
    return $urandom_range(99) >= 88;
  endfunction

  // driver: offers queued sample pairs, predicts on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      for (int k = 0; k < WINDOW; k++) begin
        x_ring[k] = '0;
        y_ring[k] = '0;
      end
      ring_slot      = 0;
      held_direction = tdc_pkg::DIR_STOP;
      tilt_thr       = tdc_pkg::THRESHOLD_RESET;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_windows(offered);
        samples_left--;
      end
      if (!in_tvalid || in_tready) begin
        if (sample_queue.size() != 0 &&
            pass_gate(idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH)) begin
          offered = sample_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {offered.y, offered.x};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus the long hold-off
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= pass_gate(idle_mode == IDLE_RECEIVER || idle_mode == IDLE_BOTH);
    end
  end

  // monitor: each accepted result against the oldest expected direction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (direction_due.size() == 0) begin
        $display("%0t unexpected item: code %0d char %0d", $time,
                 out_tdata[2:0], out_tdata[8:3]);
        mismatches++;
      end else begin
        want = direction_due.pop_front();
        if (out_tdata[2:0] !== want.code) begin
          $display("%0t direction_code mismatch: expected %0d actual %0d", $time,
                   want.code, out_tdata[2:0]);
          mismatches++;
        end
        if (out_tdata[8:3] !== want.chr) begin
          $display("%0t direction_char mismatch: expected %0d actual %0d", $time,
                   want.chr, out_tdata[8:3]);
          mismatches++;
        end
      end
    end
  end

  function automatic logic signed [tdc_pkg::SAMPLE_W-1:0] clamp16(input int v);
    if (v > 32767)  return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return tdc_pkg::SAMPLE_W'(v);
  endfunction

  task automatic push_sample(input int x, input int y);
    sample_t s;
    s.x = clamp16(x);
    s.y = clamp16(y);
    sample_queue.push_back(s);
    samples_left++;
  endtask

  // mostly runs that hold one tilt long enough to settle the averages, some noise
  task automatic queue_random_samples(input int n);
    int made;
    int kind;
    int run;
    int thr;
    int mag;
    int bx;
    int by;
    made = 0;
    while (made < n) begin
      thr = int'(tilt_thr);
      if ($urandom_range(99) < 75) begin
        kind = $urandom_range(4);
        run  = $urandom_range(3, 9);
        mag  = thr + int'($urandom_range(1, 4000));
        if (mag > 32767) mag = 32767;
        bx = int'($urandom_range(0, 2 * thr)) - thr;
        by = int'($urandom_range(0, 2 * thr)) - thr;
        case (kind)
          0: begin
            bx = bx / 2;
            by = by / 2;
          end
          1: by = -mag;
          2: by = mag;
          3: bx = mag;
          default: bx = -mag;
        endcase
        for (int k = 0; k < run && made < n; k++) begin
          push_sample(bx + int'($urandom_range(0, 1000)) - 500,
                      by + int'($urandom_range(0, 1000)) - 500);
          made++;
        end
      end else begin
        push_sample(int'($signed(16'($urandom))), int'($signed(16'($urandom))));
        made++;
      end
    end
  endtask

  // block idle: nothing left to send, nothing expected, pipeline drained
  task automatic wait_idle();
    while (samples_left != 0 || direction_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tdc_pkg::CFG_AW-1:0] addr,
                           input logic [tdc_pkg::CFG_DW-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == tdc_pkg::ADDR_TILT_THRESHOLD) tilt_thr = data[tdc_pkg::THR_W-1:0];
  endtask

  // main sequence
  initial begin
    logic [tdc_pkg::CFG_DW-1:0] thr_word;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset threshold: full-scale samples on each axis, priority of y over x
    push_sample(0, 0);
    push_sample(0, -32768);
    push_sample(0, -32768);
    push_sample(0, 32767);
    push_sample(0, 32767);
    push_sample(32767, 32767);
    push_sample(32767, 32767);
    push_sample(-32768, 0);
    push_sample(-32768, 0);
    push_sample(-32768, 0);
    push_sample(-5001, 0);
    push_sample(32767, 0);
    wait_idle();

    // zero threshold: truncated averages, any nonzero average tilts
    write_reg(tdc_pkg::ADDR_TILT_THRESHOLD, '0);
    for (int k = 0; k < WINDOW; k++) push_sample(0, 0);
    push_sample(4, 0);
    push_sample(1, 0);
    push_sample(0, -6);
    wait_idle();

    // largest threshold, upper bits of the write dropped
    write_reg(tdc_pkg::ADDR_TILT_THRESHOLD, 32'hFFFF_FFFF);
    for (int k = 0; k < WINDOW; k++) push_sample(0, -32768);
    push_sample(32767, 0);
    wait_idle();

    // write beyond the register map is ignored
    write_reg(ADDR_UNMAPPED, $urandom);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      idle_mode = idle_mode_t'(p % 4);
      thr_word  = ($urandom << tdc_pkg::THR_W) | $urandom_range(500, 15000);
      if (p == 1) thr_word = 32'd1;
      else if (p == 3) thr_word = {17'($urandom), tdc_pkg::THRESHOLD_RESET};
      else if (p == PHASE_COUNT - 1) thr_word = 32'h0000_7FFF;
      if (p != 0) write_reg(tdc_pkg::ADDR_TILT_THRESHOLD, thr_word);
      if (p == 4) hold_req <= ~hold_req;
      queue_random_samples(PHASE_ITEMS);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS tilt_direction_classifier_top");
    end else begin
      $display("FAIL tilt_direction_classifier_top");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAIL tilt_direction_classifier_top");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tdc_pkg.sv
hw/rtl/tdc_lane.sv
hw/rtl/tdc_merge.sv
hw/rtl/tilt_direction_classifier_top.sv
tb/sv/tb.sv
